// File: hdl/arena_allocator_with_free_list_defines.svh
// assertion macros shared by the arena allocator rtl
`ifndef ARENA_ALLOCATOR_WITH_FREE_LIST_DEFINES_SVH
`define ARENA_ALLOCATOR_WITH_FREE_LIST_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define AFL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define AFL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/afl_pkg.sv
// shared types and constants of the arena allocator
package afl_pkg;

	// field widths
	localparam int ADDR_W  = 16;
	localparam int SIZE_W  = 16;
	localparam int BYTES_W = 17;
	localparam int OP_W    = 18;

	// request kinds
	localparam logic [1:0] REQ_ALLOC  = 2'd0;
	localparam logic [1:0] REQ_FREE   = 2'd1;
	localparam logic [1:0] REQ_LOOKUP = 2'd2;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NOSPACE  = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_FULL     = 3'd3,
		ST_NOINIT   = 3'd4,
		ST_ZERO     = 3'd5
	} status_t;

	// slack mark meaning no fitting free block seen yet
	localparam logic [OP_W-1:0] SLACK_NONE = 18'h30000;

	// one table entry: start offset and size in bytes
	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [SIZE_W-1:0] size;
	} blk_t;

	// operands of the shared subtract and compare unit
	typedef struct packed {
		logic [OP_W-1:0] a;
		logic [OP_W-1:0] b;
		logic [OP_W-1:0] c;
	} alu_op_t;

	// results of the shared unit
	typedef struct packed {
		logic [OP_W-1:0] diff;
		logic            lt;
		logic            eq;
	} alu_res_t;

endpackage

// File: hdl/arena_allocator_with_free_list.sv
// top level of the arena allocator: sequencer, tables and bump pointer
//
// channel  | direction | handshake                 | payload
// request  | in        | start, busy               | req_type, size_bits, address
// result   | out       | done (one-cycle strobe)   | status, block_address, freed_bits
// config   | in        | cfg_valid, cfg_ready      | arena_bytes
//
// an item is taken when start is high and busy is low; busy stays high while it runs
// free and lookup scan the allocation table one entry a cycle, up to MAX_ALLOCS entries
// allocate scans the valid bits for a slot (up to MAX_ALLOCS) and tries the bump pointer;
// best fit then scans the free table, takes the block and packs the table behind it;
// done pulses in the cycle after the last step
// reset clears the bump pointer, all allocation valid bits and the free count at once
// the result is shown for one cycle only; the receiver cannot stall it
`include "arena_allocator_with_free_list_defines.svh"

module arena_allocator_with_free_list #(
	parameter int MAX_ALLOCS = 16,
	parameter int MAX_FREE   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [18:0] size_bits,
	input  logic [15:0] address,
	output logic        done,
	output logic [2:0]  status,
	output logic [15:0] block_address,
	output logic [18:0] freed_bits,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] arena_bytes
);
	import afl_pkg::*;

	localparam int AIW = $clog2(MAX_ALLOCS);
	localparam int FIW = $clog2(MAX_FREE);
	localparam int FCW = $clog2(MAX_FREE + 1);
	localparam int IW  = (AIW > FIW) ? AIW : FIW;
	localparam int CW  = FIW + 1;
	localparam int AXW = AIW + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_A_SLOT,
		S_A_BUMP,
		S_F_SCAN,
		S_B_SCAN,
		S_B_TAKE,
		S_B_SHIFT
	} state_t;

	state_t                state_q;
	logic [1:0]            req_q;
	logic [BYTES_W-1:0]    bytes_q;
	logic [ADDR_W-1:0]     addr_q;
	logic [IW-1:0]         idx_q;
	logic [AIW-1:0]        slot_q;
	logic [ADDR_W-1:0]     bump_q;
	logic [15:0]           arena_q;
	logic [MAX_ALLOCS-1:0] av_q;
	logic [FCW-1:0]        fcnt_q;
	logic [OP_W-1:0]       slack_q;
	logic [FIW-1:0]        best_q;
	logic [ADDR_W-1:0]     best_start_q;
	logic                  done_q;
	status_t               status_q;
	logic [ADDR_W-1:0]     baddr_q;
	logic [18:0]           freed_q;

	logic [19:0]           sum7;
	logic [BYTES_W-1:0]    bytes_in;
	logic [OP_W-1:0]       bump_sum;
	logic                  bump_fit;
	logic [AIW-1:0]        idx_a;
	logic [FIW-1:0]        idx_f;
	logic                  a_last;
	logic                  f_last;
	logic                  a_hit;
	alu_op_t               alu_op;
	alu_res_t              alu_res;

	logic                  a_we;
	logic [AIW-1:0]        a_waddr;
	blk_t                  a_wdata;
	logic [AIW-1:0]        a_raddr;
	blk_t                  a_rd;
	logic [AXW-1:0]        a_nxt;
	logic                  f_we;
	logic [FIW-1:0]        f_waddr;
	blk_t                  f_wdata;
	logic [FIW-1:0]        f_raddr;
	blk_t                  f_rd;
	logic [CW-1:0]         f_nxt;

	// byte count rounded up from bits
	assign sum7     = {1'b0, size_bits} + 20'd7;
	assign bytes_in = sum7[19:3];

	assign bump_sum = OP_W'(bump_q) + OP_W'(bytes_q);
	assign idx_a    = idx_q[AIW-1:0];
	assign idx_f    = idx_q[FIW-1:0];
	assign a_last   = (idx_a == AIW'(MAX_ALLOCS - 1));
	assign f_last   = ((CW'(idx_f) + CW'(1)) == CW'(fcnt_q));

	// operand select for the shared unit
	always_comb begin
		alu_op = '0;
		unique case (state_q)
			S_A_BUMP: begin
				alu_op.a = OP_W'(arena_q);
				alu_op.b = bump_sum;
			end
			S_F_SCAN: begin
				alu_op.a = OP_W'(a_rd.start);
				alu_op.b = OP_W'(addr_q);
			end
			S_B_SCAN: begin
				alu_op.a = OP_W'(f_rd.size);
				alu_op.b = OP_W'(bytes_q);
				alu_op.c = slack_q;
			end
			default: begin
				alu_op = '0;
			end
		endcase
	end

	afl_alu u_alu (
		.op  (alu_op),
		.res (alu_res)
	);

	// no borrow means bump pointer plus bytes stays inside the arena
	assign bump_fit = !alu_res.diff[OP_W-1];
	assign a_hit    = av_q[idx_a] && alu_res.eq;

	// allocation table read address runs one ahead of the scan index
	always_comb begin
		a_nxt   = AXW'(idx_a) + AXW'(1);
		a_raddr = '0;
		if (state_q == S_F_SCAN && a_nxt < AXW'(MAX_ALLOCS)) begin
			a_raddr = a_nxt[AIW-1:0];
		end
	end

	// free table read address for scan, take and pack steps
	always_comb begin
		unique case (state_q)
			S_B_SCAN:  f_nxt = CW'(idx_f) + CW'(1);
			S_B_TAKE:  f_nxt = CW'(best_q) + CW'(1);
			S_B_SHIFT: f_nxt = CW'(idx_f) + CW'(2);
			default:   f_nxt = '0;
		endcase
		f_raddr = '0;
		if (f_nxt < CW'(MAX_FREE)) begin
			f_raddr = f_nxt[FIW-1:0];
		end
	end

	// allocation table writes
	always_comb begin
		a_we    = 1'b0;
		a_waddr = slot_q;
		a_wdata = '{start: bump_q, size: bytes_q[SIZE_W-1:0]};
		if (state_q == S_A_BUMP && bump_fit) begin
			a_we = 1'b1;
		end else if (state_q == S_B_TAKE) begin
			a_we    = 1'b1;
			a_wdata = '{start: best_start_q, size: bytes_q[SIZE_W-1:0]};
		end
	end

	// free table writes: append on free, move down while packing
	always_comb begin
		f_we    = 1'b0;
		f_waddr = fcnt_q[FIW-1:0];
		f_wdata = a_rd;
		if (state_q == S_F_SCAN && a_hit && req_q == REQ_FREE
				&& fcnt_q != FCW'(MAX_FREE)) begin
			f_we = 1'b1;
		end else if (state_q == S_B_SHIFT) begin
			f_we    = 1'b1;
			f_waddr = idx_f;
			f_wdata = f_rd;
		end
	end

	afl_ram #(
		.WIDTH ($bits(blk_t)),
		.DEPTH (MAX_ALLOCS)
	) u_alloc_ram (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_waddr),
		.wdata (a_wdata),
		.raddr (a_raddr),
		.rdata (a_rd)
	);

	afl_ram #(
		.WIDTH ($bits(blk_t)),
		.DEPTH (MAX_FREE)
	) u_free_ram (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.raddr (f_raddr),
		.rdata (f_rd)
	);

	// sequencer, table state and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			req_q        <= REQ_ALLOC;
			bytes_q      <= '0;
			addr_q       <= '0;
			idx_q        <= '0;
			slot_q       <= '0;
			bump_q       <= '0;
			arena_q      <= '0;
			av_q         <= '0;
			fcnt_q       <= '0;
			slack_q      <= SLACK_NONE;
			best_q       <= '0;
			best_start_q <= '0;
			done_q       <= 1'b0;
			status_q     <= ST_OK;
			baddr_q      <= '0;
			freed_q      <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) begin
				arena_q <= arena_bytes;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q   <= req_type;
						bytes_q <= bytes_in;
						addr_q  <= address;
						idx_q   <= '0;
						baddr_q <= '0;
						freed_q <= '0;
						priority if (req_type == REQ_ALLOC) begin
							if (arena_q == '0) begin
								done_q   <= 1'b1;
								status_q <= ST_NOINIT;
							end else if (bytes_in == '0) begin
								done_q   <= 1'b1;
								status_q <= ST_ZERO;
							end else begin
								state_q <= S_A_SLOT;
							end
						end else if (req_type == REQ_FREE || req_type == REQ_LOOKUP) begin
							state_q <= S_F_SCAN;
						end else begin
							done_q   <= 1'b1;
							status_q <= ST_NOTFOUND;
						end
					end
				end
				// look for the first unused allocation slot
				S_A_SLOT: begin
					if (!av_q[idx_a]) begin
						slot_q  <= idx_a;
						state_q <= S_A_BUMP;
					end else if (a_last) begin
						done_q   <= 1'b1;
						status_q <= ST_FULL;
						state_q  <= S_IDLE;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				// place at the bump pointer or fall back to the free table
				S_A_BUMP: begin
					if (bump_fit) begin
						bump_q       <= bump_sum[ADDR_W-1:0];
						av_q[slot_q] <= 1'b1;
						done_q       <= 1'b1;
						status_q     <= ST_OK;
						baddr_q      <= bump_q;
						state_q      <= S_IDLE;
					end else if (fcnt_q == '0) begin
						done_q   <= 1'b1;
						status_q <= ST_NOSPACE;
						state_q  <= S_IDLE;
					end else begin
						idx_q   <= '0;
						slack_q <= SLACK_NONE;
						state_q <= S_B_SCAN;
					end
				end
				// free and lookup: first valid entry with a matching start
				S_F_SCAN: begin
					if (a_hit) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
						if (req_q == REQ_LOOKUP) begin
							status_q <= ST_OK;
							baddr_q  <= addr_q;
						end else if (fcnt_q == FCW'(MAX_FREE)) begin
							status_q <= ST_FULL;
						end else begin
							fcnt_q      <= fcnt_q + FCW'(1);
							av_q[idx_a] <= 1'b0;
							status_q    <= ST_OK;
							baddr_q     <= addr_q;
							freed_q     <= {a_rd.size, 3'b000};
						end
					end else if (a_last) begin
						done_q   <= 1'b1;
						status_q <= ST_NOTFOUND;
						state_q  <= S_IDLE;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				// best fit: strictly smaller slack wins, so the earliest tie stays
				S_B_SCAN: begin
					if (alu_res.lt) begin
						slack_q      <= alu_res.diff;
						best_q       <= idx_f;
						best_start_q <= f_rd.start;
					end
					if (f_last) begin
						if (alu_res.lt || slack_q != SLACK_NONE) begin
							state_q <= S_B_TAKE;
						end else begin
							done_q   <= 1'b1;
							status_q <= ST_NOSPACE;
							state_q  <= S_IDLE;
						end
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				// record the allocation and, unless the taken block is the last entry, start packing behind it
				S_B_TAKE: begin
					av_q[slot_q] <= 1'b1;
					idx_q        <= IW'(best_q);
					if ((CW'(best_q) + CW'(1)) >= CW'(fcnt_q)) begin
						fcnt_q   <= fcnt_q - FCW'(1);
						done_q   <= 1'b1;
						status_q <= ST_OK;
						baddr_q  <= best_start_q;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_B_SHIFT;
					end
				end
				// move one entry down per cycle
				S_B_SHIFT: begin
					if ((CW'(idx_f) + CW'(2)) >= CW'(fcnt_q)) begin
						fcnt_q   <= fcnt_q - FCW'(1);
						done_q   <= 1'b1;
						status_q <= ST_OK;
						baddr_q  <= best_start_q;
						state_q  <= S_IDLE;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// ports
	assign busy          = (state_q != S_IDLE);
	assign cfg_ready     = 1'b1;
	assign done          = done_q;
	assign status        = status_q;
	assign block_address = baddr_q;
	assign freed_bits    = freed_q;

	// checks
	`AFL_ASSERT_NOW(a_done_idle, done_q, state_q == S_IDLE, "result strobe while sequencer busy")
	`AFL_ASSERT_NEXT(a_bump_hold, state_q != S_A_BUMP, $stable(bump_q), "bump pointer moved outside placement step")
	`AFL_ASSERT_NOW(a_take_best, state_q == S_B_TAKE, slack_q != SLACK_NONE, "free block taken without a fitting candidate")
	`AFL_ASSERT_NOW(a_shift_range, state_q == S_B_SHIFT, (CW'(idx_f) + CW'(1)) < CW'(fcnt_q), "packing past the end of the free table")

endmodule

// File: hdl/afl_ram.sv
// generic single write port ram with registered read
module afl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/afl_alu.sv
// shared subtract and compare unit used by the bump check and both table scans
module afl_alu (
	input  afl_pkg::alu_op_t  op,
	output afl_pkg::alu_res_t res
);
	import afl_pkg::*;

	logic [OP_W-1:0] diff;

	// difference wraps; its msb is the borrow for operands below 2**17
	always_comb begin
		diff     = op.a - op.b;
		res.diff = diff;
		res.lt   = (diff < op.c);
		res.eq   = (op.a == op.b);
	end

endmodule

// File: tb/arena_checker.sv
// result checker for the arena allocator: predicts each request and compares results
`timescale 1ns / 100ps

module arena_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  req_type,
	input  logic [18:0] size_bits,
	input  logic [15:0] address,
	input  logic        done,
	input  logic [2:0]  status,
	input  logic [15:0] block_address,
	input  logic [18:0] freed_bits,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] arena_bytes,
	output int          outstanding,
	output int          mismatches
);
	import afl_pkg::*;

	localparam int ALLOC_SLOTS = 16;
	localparam int FREE_SLOTS  = 16;

	// one predicted result
	typedef struct {
		status_t     st;
		logic [15:0] blk;
		logic [18:0] bits;
	} outcome_t;

	outcome_t    results_due[$];
	outcome_t    oldest;

	// predicted allocator state
	logic [15:0] arena_size;
	logic [15:0] bump_ptr;
	logic        alloc_live  [ALLOC_SLOTS];
	logic [15:0] alloc_start [ALLOC_SLOTS];
	logic [15:0] alloc_len   [ALLOC_SLOTS];
	logic [15:0] free_start  [FREE_SLOTS];
	logic [15:0] free_len    [FREE_SLOTS];
	int          free_cnt;

	// apply one request to the predicted state and return its result
	function automatic outcome_t serve_request(input logic [1:0] kind,
			input logic [18:0] bits, input logic [15:0] addr);
		outcome_t res;
		int nbytes;
		int slot;
		int hit;
		int best;
		int place;
		res.st   = ST_NOTFOUND;
		res.blk  = '0;
		res.bits = '0;
		nbytes   = (int'(bits) + 7) >> 3;
		slot     = -1;
		hit      = -1;
		for (int i = 0; i < ALLOC_SLOTS; i++) begin
			if (!alloc_live[i] && slot < 0)
				slot = i;
			if (alloc_live[i] && alloc_start[i] == addr && hit < 0)
				hit = i;
		end
		case (kind)
			REQ_ALLOC: begin
				if (arena_size == 0)
					res.st = ST_NOINIT;
				else if (nbytes == 0)
					res.st = ST_ZERO;
				else if (slot < 0)
					res.st = ST_FULL;
				else begin
					place = -1;
					// bump pointer first, then smallest fitting freed block
					if (bump_ptr <= arena_size &&
							nbytes <= int'(arena_size) - int'(bump_ptr)) begin
						place    = int'(bump_ptr);
						bump_ptr = 16'(int'(bump_ptr) + nbytes);
					end else begin
						best = -1;
						for (int k = 0; k < free_cnt; k++)
							if (free_len[k] >= nbytes &&
									(best < 0 || free_len[k] < free_len[best]))
								best = k;
						if (best >= 0) begin
							place = int'(free_start[best]);
							for (int k = best; k < free_cnt - 1; k++) begin
								free_start[k] = free_start[k + 1];
								free_len[k]   = free_len[k + 1];
							end
							free_cnt--;
						end
					end
					if (place < 0)
						res.st = ST_NOSPACE;
					else begin
						alloc_live[slot]  = 1'b1;
						alloc_start[slot] = 16'(place);
						alloc_len[slot]   = 16'(nbytes);
						res.st  = ST_OK;
						res.blk = 16'(place);
					end
				end
			end
			REQ_FREE: begin
				if (hit < 0)
					res.st = ST_NOTFOUND;
				else if (free_cnt >= FREE_SLOTS)
					res.st = ST_FULL;
				else begin
					free_start[free_cnt] = alloc_start[hit];
					free_len[free_cnt]   = alloc_len[hit];
					free_cnt++;
					alloc_live[hit] = 1'b0;
					res.st   = ST_OK;
					res.blk  = addr;
					res.bits = {alloc_len[hit], 3'b000};
				end
			end
			REQ_LOOKUP: begin
				if (hit >= 0) begin
					res.st  = ST_OK;
					res.blk = addr;
				end
			end
			default: res.st = ST_NOTFOUND;
		endcase
		return res;
	endfunction

	// watch the channels: results first, then config, then new requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arena_size = '0;
			bump_ptr   = '0;
			free_cnt   = 0;
			for (int i = 0; i < ALLOC_SLOTS; i++)
				alloc_live[i] = 1'b0;
			results_due.delete();
			outstanding <= 0;
			mismatches  <= 0;
		end else begin
			if (done) begin
				if (results_due.size() == 0) begin
					$error("result with no request pending: status %0d", status);
					mismatches <= mismatches + 1;
				end else begin
					oldest = results_due.pop_front();
					if (status !== oldest.st || block_address !== oldest.blk ||
							freed_bits !== oldest.bits)
						mismatches <= mismatches + 1;
					if (status !== oldest.st)
						$error("status: expected %0d, got %0d", oldest.st, status);
					if (block_address !== oldest.blk)
						$error("block_address: expected %0d, got %0d",
							oldest.blk, block_address);
					if (freed_bits !== oldest.bits)
						$error("freed_bits: expected %0d, got %0d",
							oldest.bits, freed_bits);
				end
			end
			if (cfg_valid && cfg_ready)
				arena_size = arena_bytes;
			if (start && !busy)
				results_due.push_back(serve_request(req_type, size_bits, address));
			outstanding <= results_due.size();
		end
	end

endmodule

// File: tb/testbench.sv
// top of the arena allocator testbench: clock, reset, request stimulus and verdict
`timescale 1ns / 100ps

module testbench;
	import afl_pkg::*;

	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	localparam int         PHASES      = 12;
	localparam int         PHASE_ITEMS = 100;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        start       = 1'b0;
	logic [1:0]  req_type    = '0;
	logic [18:0] size_bits   = '0;
	logic [15:0] address     = '0;
	logic        cfg_valid   = 1'b0;
	logic [15:0] arena_bytes = '0;
	logic        busy;
	logic        done;
	logic [2:0]  status;
	logic [15:0] block_address;
	logic [18:0] freed_bits;
	logic        cfg_ready;
	int          outstanding;
	int          mismatches;

	// addresses the block has handed out, used to aim frees and lookups
	logic [15:0] addr_pool[$];

	arena_allocator_with_free_list dut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy),
		.req_type(req_type), .size_bits(size_bits), .address(address),
		.done(done), .status(status), .block_address(block_address),
		.freed_bits(freed_bits),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .arena_bytes(arena_bytes)
	);

	arena_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy),
		.req_type(req_type), .size_bits(size_bits), .address(address),
		.done(done), .status(status), .block_address(block_address),
		.freed_bits(freed_bits),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .arena_bytes(arena_bytes),
		.outstanding(outstanding), .mismatches(mismatches)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// collect good block addresses on the quiet edge
	always @(negedge clk) begin
		if (arst_n && done && status == ST_OK) begin
			addr_pool.push_back(block_address);
			if (addr_pool.size() > 32)
				void'(addr_pool.pop_front());
		end
	end

	// present one request after a gap and hold it until taken
	task automatic issue_request(input logic [1:0] kind, input logic [18:0] bits,
			input logic [15:0] addr, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		req_type  <= kind;
		size_bits <= bits;
		address   <= addr;
		do @(posedge clk); while (busy);
	endtask

	// stop sending and wait until every result is back
	task automatic wait_all_results();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// write the arena size while the block is idle
	task automatic set_arena_size(input logic [15:0] value);
		cfg_valid   <= 1'b1;
		arena_bytes <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// stimulus and verdict
	initial begin
		int          r;
		int          alloc_weight;
		int          gap;
		int          pick;
		bit          no_idle;
		logic [1:0]  kind;
		logic [18:0] bits;
		logic [15:0] addr;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// arena not set up yet: allocate refused, free, lookup and an unknown kind miss
		issue_request(REQ_ALLOC, 19'd8, 16'd0, $urandom_range(0, 16));
		issue_request(REQ_FREE, 19'd0, 16'd0, $urandom_range(0, 16));
		issue_request(REQ_LOOKUP, 19'd0, 16'd0, $urandom_range(0, 16));
		issue_request(REQ_UNKNOWN, 19'h7ffff, 16'hffff, $urandom_range(0, 16));
		wait_all_results();
		set_arena_size(16'hffff);

		// zero size, oversize, whole arena, then reuse of the freed block
		issue_request(REQ_ALLOC, 19'd0, 16'd0, $urandom_range(0, 16));
		issue_request(REQ_ALLOC, 19'h7ffff, 16'd0, $urandom_range(0, 16));
		issue_request(REQ_ALLOC, 19'd524280, 16'd0, $urandom_range(0, 16));
		issue_request(REQ_ALLOC, 19'd1, 16'd0, $urandom_range(0, 16));
		issue_request(REQ_LOOKUP, 19'd0, 16'd0, $urandom_range(0, 16));
		issue_request(REQ_FREE, 19'd0, 16'd0, $urandom_range(0, 16));
		issue_request(REQ_FREE, 19'd0, 16'd0, $urandom_range(0, 16));
		issue_request(REQ_ALLOC, 19'd9, 16'd0, $urandom_range(0, 16));
		issue_request(REQ_ALLOC, 19'd7, 16'd0, $urandom_range(0, 16));
		issue_request(REQ_LOOKUP, 19'd0, 16'hffff, $urandom_range(0, 16));
		issue_request(REQ_FREE, 19'd0, 16'd0, $urandom_range(0, 16));
		wait_all_results();

		// arena shrunk below the bump pointer: only freed blocks can serve
		set_arena_size(16'd1);
		issue_request(REQ_ALLOC, 19'd1, 16'd0, $urandom_range(0, 16));
		issue_request(REQ_ALLOC, 19'd1, 16'd0, $urandom_range(0, 16));
		issue_request(REQ_LOOKUP, 19'd0, 16'd0, $urandom_range(0, 16));

		// random phases, each at its own arena size and request mix
		for (int phase = 0; phase < PHASES; phase++) begin
			wait_all_results();
			case (phase % 6)
				0: set_arena_size(16'hffff);
				1: set_arena_size(16'($urandom_range(1, 32)));
				2: set_arena_size(16'($urandom_range(33, 512)));
				3: set_arena_size(16'($urandom_range(0, 65535)));
				4: set_arena_size(16'd0);
				default: set_arena_size(16'($urandom_range(1, 8)));
			endcase
			alloc_weight = $urandom_range(30, 70);
			no_idle      = (phase % 3 == 0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(0, 99);
				if (r < alloc_weight)
					kind = REQ_ALLOC;
				else if (r < alloc_weight + (100 - alloc_weight) * 55 / 100)
					kind = REQ_FREE;
				else if (r < alloc_weight + (100 - alloc_weight) * 90 / 100)
					kind = REQ_LOOKUP;
				else
					kind = REQ_UNKNOWN;
				// mostly small sizes, sometimes extremes
				case ($urandom_range(0, 9))
					0: bits = '0;
					1: bits = 19'($urandom_range(0, 524287));
					2: bits = 19'(524280 + $urandom_range(0, 7));
					default: bits = 19'($urandom_range(1, 64));
				endcase
				// mostly addresses that were handed out
				pick = $urandom_range(0, 9);
				if (pick < 7 && addr_pool.size() > 0)
					addr = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
				else if (pick == 7)
					addr = 16'($urandom_range(0, 65535));
				else
					addr = 16'($urandom_range(0, 64));
				gap = (no_idle || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
				issue_request(kind, bits, addr, gap);
			end
		end

		wait_all_results();
		repeat (64) @(posedge clk);
		if (mismatches == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	// run limit
	initial begin
		#5000000;
		$display("testbench: errors");
		$finish;
	end

endmodule

// File: arena_allocator_with_free_list.f
+incdir+hdl
hdl/afl_pkg.sv
hdl/afl_ram.sv
hdl/afl_alu.sv
hdl/arena_allocator_with_free_list.sv
tb/arena_checker.sv
tb/testbench.sv
